### rtl/takf_pkg.sv
// Package: shared types, constants and state encoding for the tilt-angle Kalman filter.
package takf_pkg;

    localparam int COV_FRAC_BITS = 40;
    localparam int COV_W         = 48;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 40;
    localparam int CFG_IDX_W     = 2;
    localparam int DIV_STEPS     = 63 + COV_FRAC_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

    // multiply step sequence: partial products 0..3, then round, then accumulate
    localparam logic [2:0] MUL_ROUND = 3'd4;
    localparam logic [2:0] MUL_LAST  = 3'd5;

    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = 40'd10995116278;
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = 40'd109951163;
    localparam logic [23:0]      MEASURE_NOISE_RST = 24'd655360;
    localparam logic [23:0]      SAMPLE_PERIOD_RST = 24'd83886;

    localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(64'sd1 <<< COV_FRAC_BITS);
    localparam logic signed [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};
    localparam logic [63:0] MAG_CLAMP = 64'd1 << 62;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_NOISE   = 2'd0,
        REG_BIAS_NOISE    = 2'd1,
        REG_MEASURE_NOISE = 2'd2,
        REG_SAMPLE_PERIOD = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_ANG,   // angle += (rm - bias)*dt
        ST_P_AA,
        ST_P_AB,
        ST_P_BA,
        ST_P_BB,
        ST_GAIN_SET,
        ST_DIV0,
        ST_DIV1,
        ST_C_AA,
        ST_C_AB,
        ST_C_BA,
        ST_C_BB,
        ST_C_ANG,
        ST_C_BIAS,
        ST_OUT
    } t_state;

    function automatic logic signed [63:0] sat_to(input logic signed [65:0] x,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
        logic signed [65:0] l, h;
        begin
            l = 66'(lo);
            h = 66'(hi);
            if (x < l) begin
                sat_to = lo;
            end else if (x > h) begin
                sat_to = hi;
            end else begin
                sat_to = 64'(x);
            end
        end
    endfunction

endpackage

### rtl/takf_stream_if.sv
// Interface: valid/ready channel carrying a pair of 32-bit fields.
interface takf_stream_if;
    logic        valid;
    logic        ready;
    logic [31:0] f0;
    logic [31:0] f1;

    modport source (output valid, output f0, output f1, input ready);
    modport sink   (input valid, input f0, input f1, output ready);
endinterface

### rtl/tilt_angle_kalman_filter_top.sv
// Top level: iterative two-state angle/gyro-bias Kalman filter.
//
// Usage:
//   s_in  (sink)  : f0 = angle_meas, f1 = rate_meas, both signed Q16.16.
//   m_out (source): f0 = angle_est,  f1 = rate_est,  both signed Q16.16.
//   Configuration: i_cfg_we, i_cfg_idx (0 angle_noise, 1 bias_noise,
//   2 measure_noise, 3 sample_period) and i_cfg_data; write while idle.
// Schedule:
//   Eleven multiply steps share one 25x25 multiplier, each as four partial
//   products, a round and an accumulate; the two gains come from a radix-2
//   serial divider, one after the other, when the divisor (measure_noise
//   plus cov_aa) is positive, and are zero with no division otherwise.
//   s_in.ready is low from acceptance until the result has been taken, so
//   no new item is accepted before the last one is through.
// Reset:
//   Estimates go to zero, cov_aa and cov_bb to one, the cross terms to
//   zero, and the registers to their default values.
// Stall:
//   The result is held in the output register until taken; a new item is
//   accepted only after the result has left.
module tilt_angle_kalman_filter_top
    import takf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    takf_stream_if.sink          s_in,
    takf_stream_if.source        m_out
);

    logic [CFG_W-1:0] r_qa_reg, r_qg_reg;
    logic [23:0]      r_rn_reg, r_dt_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa_reg <= ANGLE_NOISE_RST;
            r_qg_reg <= BIAS_NOISE_RST;
            r_rn_reg <= MEASURE_NOISE_RST;
            r_dt_reg <= SAMPLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ANGLE_NOISE:   r_qa_reg <= i_cfg_data;
                REG_BIAS_NOISE:    r_qg_reg <= i_cfg_data;
                REG_MEASURE_NOISE: r_rn_reg <= i_cfg_data[23:0];
                REG_SAMPLE_PERIOD: r_dt_reg <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Noise values at COV_FRAC_BITS fraction bits
    logic signed [63:0] qa, qg, rn;
    always_comb begin
        if (COV_FRAC_BITS >= 40) begin
            qa = $signed(64'(r_qa_reg) << (COV_FRAC_BITS - 40));
            qg = $signed(64'(r_qg_reg) << (COV_FRAC_BITS - 40));
        end else begin
            qa = $signed((64'(r_qa_reg) + (64'd1 << (39 - COV_FRAC_BITS)))
                         >> (40 - COV_FRAC_BITS));
            qg = $signed((64'(r_qg_reg) + (64'd1 << (39 - COV_FRAC_BITS)))
                         >> (40 - COV_FRAC_BITS));
        end
        rn = $signed(64'(r_rn_reg) << (COV_FRAC_BITS - 16));
    end

    t_state r_state, n_state;
    logic signed [31:0]    r_ang, r_bias, r_am, r_rm;
    logic signed [COV_W-1:0] r_aa, r_ab, r_ba, r_bb, r_k0, r_k1, r_t0, r_t1;
    logic signed [32:0]    r_err;
    logic [2:0]            r_mstep;          // position in the multiply sequence
    logic [127:0]          r_pacc;           // exact magnitude product
    logic                  r_pneg;
    logic signed [63:0]    r_mres;           // rounded, signed product
    logic                  r_ovalid;
    logic [31:0]           r_oang, r_orate;

    // divider
    logic [63:0]          r_dnum, r_dden, r_drem, r_dq;
    logic                 r_dover, r_dneg;
    logic [DIV_CNT_W-1:0] r_dcnt;

    // --- shared multiplier operand selection ---
    logic signed [63:0] op_a, op_b;
    logic [6:0]         sh;
    always_comb begin
        op_a = '0;
        op_b = '0;
        sh   = 7'd24;
        unique case (r_state)
            ST_P_ANG: begin
                op_a = 64'(r_rm) - 64'(r_bias);
                op_b = 64'(r_dt_reg);
            end
            ST_P_AA: begin
                op_a = qa - 64'(r_ab) - 64'(r_ba);
                op_b = 64'(r_dt_reg);
            end
            ST_P_AB, ST_P_BA: begin
                op_a = -64'(r_bb);
                op_b = 64'(r_dt_reg);
            end
            ST_P_BB: begin
                op_a = qg;
                op_b = 64'(r_dt_reg);
            end
            ST_C_AA: begin op_a = 64'(r_k0); op_b = 64'(r_t0); sh = 7'(COV_FRAC_BITS); end
            ST_C_AB: begin op_a = 64'(r_k0); op_b = 64'(r_t1); sh = 7'(COV_FRAC_BITS); end
            ST_C_BA: begin op_a = 64'(r_k1); op_b = 64'(r_t0); sh = 7'(COV_FRAC_BITS); end
            ST_C_BB: begin op_a = 64'(r_k1); op_b = 64'(r_t1); sh = 7'(COV_FRAC_BITS); end
            ST_C_ANG: begin op_a = 64'(r_k0); op_b = 64'(r_err); sh = 7'(COV_FRAC_BITS); end
            ST_C_BIAS: begin op_a = 64'(r_k1); op_b = 64'(r_err); sh = 7'(COV_FRAC_BITS); end
            default: ;
        endcase
    end

    // operand magnitudes never exceed 50 bits; build the product from four
    // 25x25 partial products, one per cycle
    logic [63:0]  mag_a, mag_b;
    logic [24:0]  pa, pb;
    logic [49:0]  pp;
    logic [127:0] pp_sh;
    assign mag_a = op_a[63] ? 64'(-op_a) : 64'(op_a);
    assign mag_b = op_b[63] ? 64'(-op_b) : 64'(op_b);
    assign pa    = r_mstep[1] ? mag_a[49:25] : mag_a[24:0];
    assign pb    = r_mstep[0] ? mag_b[49:25] : mag_b[24:0];
    assign pp    = 50'(pa) * 50'(pb);
    always_comb begin
        unique case (r_mstep[1:0])
            2'd0:       pp_sh = 128'(pp);
            2'd1, 2'd2: pp_sh = 128'(pp) << 25;
            default:    pp_sh = 128'(pp) << 50;
        endcase
    end

    // rounding and clamping of the accumulated product
    logic [127:0]       rnd_sum, shifted;
    logic [63:0]        rmag;
    logic signed [63:0] mres;
    always_comb begin
        rnd_sum = r_pacc + (128'd1 << (sh - 7'd1));
        shifted = rnd_sum >> sh;
        if (shifted > 128'(MAG_CLAMP)) begin
            rmag = MAG_CLAMP;
        end else begin
            rmag = shifted[63:0];
        end
        mres = r_pneg ? -$signed(rmag) : $signed(rmag);
    end

    // accumulate with saturation
    logic signed [65:0] acc_in;
    logic signed [63:0] acc_sat;
    logic               acc_is32;
    always_comb begin
        acc_in   = '0;
        acc_is32 = 1'b0;
        unique case (r_state)
            ST_P_ANG:  begin acc_in = 66'(r_ang) + 66'(r_mres); acc_is32 = 1'b1; end
            ST_P_AA:   acc_in = 66'(r_aa) + 66'(r_mres);
            ST_P_AB:   acc_in = 66'(r_ab) + 66'(r_mres);
            ST_P_BA:   acc_in = 66'(r_ba) + 66'(r_mres);
            ST_P_BB:   acc_in = 66'(r_bb) + 66'(r_mres);
            ST_C_AA:   acc_in = 66'(r_aa) - 66'(r_mres);
            ST_C_AB:   acc_in = 66'(r_ab) - 66'(r_mres);
            ST_C_BA:   acc_in = 66'(r_ba) - 66'(r_mres);
            ST_C_BB:   acc_in = 66'(r_bb) - 66'(r_mres);
            ST_C_ANG:  begin acc_in = 66'(r_ang) + 66'(r_mres); acc_is32 = 1'b1; end
            ST_C_BIAS: begin acc_in = 66'(r_bias) + 66'(r_mres); acc_is32 = 1'b1; end
            default: ;
        endcase
        if (acc_is32) begin
            acc_sat = sat_to(acc_in, 64'sh80000000 | 64'hFFFFFFFF00000000,
                             64'sh7FFFFFFF);
        end else begin
            acc_sat = sat_to(acc_in, 64'(COV_MIN), 64'(COV_MAX));
        end
    end

    // divider step
    logic [63:0] rem_sh, num_bit;
    logic        d_ge;
    logic [DIV_CNT_W-1:0] bit_i;
    always_comb begin
        bit_i   = r_dcnt - DIV_CNT_W'(1);
        num_bit = (bit_i >= DIV_CNT_W'(COV_FRAC_BITS))
                  ? ((r_dnum >> (bit_i - DIV_CNT_W'(COV_FRAC_BITS))) & 64'd1) : 64'd0;
        rem_sh  = {r_drem[62:0], num_bit[0]};
        d_ge    = (rem_sh >= r_dden);
    end

    logic [63:0]        q_fin;
    logic signed [COV_W-1:0] k_fin;
    always_comb begin
        q_fin = (r_dover || r_dq > 64'(COV_MAX)) ? 64'(COV_MAX) + 64'd1 : r_dq;
        if (r_dneg) begin
            k_fin = COV_W'(-$signed(q_fin));
        end else if (q_fin > 64'(COV_MAX)) begin
            k_fin = COV_MAX;
        end else begin
            k_fin = COV_W'(q_fin);
        end
    end

    logic signed [63:0] e_sum;
    assign e_sum = rn + 64'(r_aa);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (s_in.valid && s_in.ready) n_state = ST_P_ANG;
            ST_P_ANG:    if (r_mstep == MUL_LAST) n_state = ST_P_AA;
            ST_P_AA:     if (r_mstep == MUL_LAST) n_state = ST_P_AB;
            ST_P_AB:     if (r_mstep == MUL_LAST) n_state = ST_P_BA;
            ST_P_BA:     if (r_mstep == MUL_LAST) n_state = ST_P_BB;
            ST_P_BB:     if (r_mstep == MUL_LAST) n_state = ST_GAIN_SET;
            ST_GAIN_SET: n_state = (e_sum > 0) ? ST_DIV0 : ST_C_AA;
            ST_DIV0:     if (r_dcnt == '0) n_state = ST_DIV1;
            ST_DIV1:     if (r_dcnt == '0) n_state = ST_C_AA;
            ST_C_AA:     if (r_mstep == MUL_LAST) n_state = ST_C_AB;
            ST_C_AB:     if (r_mstep == MUL_LAST) n_state = ST_C_BA;
            ST_C_BA:     if (r_mstep == MUL_LAST) n_state = ST_C_BB;
            ST_C_BB:     if (r_mstep == MUL_LAST) n_state = ST_C_ANG;
            ST_C_ANG:    if (r_mstep == MUL_LAST) n_state = ST_C_BIAS;
            ST_C_BIAS:   if (r_mstep == MUL_LAST) n_state = ST_OUT;
            ST_OUT:      n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    assign s_in.ready  = (r_state == ST_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.f0    = r_oang;
    assign m_out.f1    = r_orate;

    logic signed [63:0] rate_sat;
    assign rate_sat = sat_to(66'(r_rm) - 66'(r_bias),
                             64'sh80000000 | 64'hFFFFFFFF00000000, 64'sh7FFFFFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mstep  <= '0;
            r_ovalid <= 1'b0;
            r_ang    <= '0;
            r_bias   <= '0;
            r_aa     <= COV_ONE;
            r_ab     <= '0;
            r_ba     <= '0;
            r_bb     <= COV_ONE;
            r_dcnt   <= '0;
        end else begin
            r_state <= n_state;
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_mstep <= '0;
                    if (s_in.valid && s_in.ready) begin
                        r_am <= $signed(s_in.f0);
                        r_rm <= $signed(s_in.f1);
                    end
                end
                ST_P_ANG, ST_P_AA, ST_P_AB, ST_P_BA, ST_P_BB,
                ST_C_AA, ST_C_AB, ST_C_BA, ST_C_BB, ST_C_ANG, ST_C_BIAS: begin
                    r_mstep <= (r_mstep == MUL_LAST) ? 3'd0 : r_mstep + 3'd1;
                    if (r_mstep == 3'd0) begin
                        r_pacc <= 128'(pp);
                        r_pneg <= op_a[63] ^ op_b[63];
                    end else if (r_mstep < MUL_ROUND) begin
                        r_pacc <= r_pacc + pp_sh;
                    end else if (r_mstep == MUL_ROUND) begin
                        r_mres <= mres;
                    end else begin
                        unique case (r_state)
                            ST_P_ANG, ST_C_ANG: r_ang <= 32'(acc_sat);
                            ST_C_BIAS:          r_bias <= 32'(acc_sat);
                            ST_P_AA, ST_C_AA:   r_aa <= COV_W'(acc_sat);
                            ST_P_AB, ST_C_AB:   r_ab <= COV_W'(acc_sat);
                            ST_P_BA, ST_C_BA:   r_ba <= COV_W'(acc_sat);
                            default:            r_bb <= COV_W'(acc_sat);
                        endcase
                    end
                end
                ST_GAIN_SET: begin
                    r_err  <= 33'(r_am) - 33'(r_ang);
                    r_t0   <= r_aa;
                    r_t1   <= r_ab;
                    r_k0   <= '0;
                    r_k1   <= '0;
                    r_dden <= 64'(e_sum);
                    r_dnum <= r_aa[COV_W-1] ? 64'(-64'(r_aa)) : 64'(r_aa);
                    r_dneg <= r_aa[COV_W-1];
                    r_drem <= '0;
                    r_dq   <= '0;
                    r_dover <= 1'b0;
                    r_dcnt <= DIV_CNT_W'(DIV_STEPS);
                end
                ST_DIV0, ST_DIV1: begin
                    if (r_dcnt != '0) begin
                        if (r_dq >= MAG_CLAMP) r_dover <= 1'b1;
                        r_dq   <= {1'b0, r_dq[61:0], d_ge};
                        r_drem <= d_ge ? rem_sh - r_dden : rem_sh;
                        r_dcnt <= r_dcnt - DIV_CNT_W'(1);
                    end else begin
                        // second gain reuses the divider with cov_ba
                        if (r_state == ST_DIV0) begin
                            r_k0   <= k_fin;
                            r_dnum <= r_ba[COV_W-1] ? 64'(-64'(r_ba)) : 64'(r_ba);
                            r_dneg <= r_ba[COV_W-1];
                            r_drem <= '0;
                            r_dq   <= '0;
                            r_dover <= 1'b0;
                            r_dcnt <= DIV_CNT_W'(DIV_STEPS);
                        end else begin
                            r_k1 <= k_fin;
                        end
                    end
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_oang   <= r_ang;
                    r_orate  <= 32'(rate_sat);
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/takf_checker.sv
// Checker: port-level properties of the Kalman filter top level, with its bind.
module takf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_f0,
    input logic [31:0] out_f1
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_f0) && $stable(out_f1))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while result pending");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result without work");

endmodule

bind tilt_angle_kalman_filter_top takf_checker u_takf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (s_in.valid),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_f0    (m_out.f0),
    .out_f1    (m_out.f1)
);

### tb/tb_top.sv
// Self-checking testbench for the tilt-angle Kalman filter: directed, sweep and random items.
module tb_top;
    import takf_pkg::*;

    localparam int  LIMIT_CYCLES = 3_000_000;
    localparam int  SETTLE       = 300;

    typedef struct {
        logic [31:0] angle;
        logic [31:0] rate;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    takf_stream_if in_ch ();
    takf_stream_if out_ch ();

    tilt_angle_kalman_filter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // filter copy: registers and state
    longint q_angle, q_bias, r_meas, dt;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    t_estimate estimates_due[$];

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_cfg = 0;
    longint cycles = 0;
    bit send_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    int stall_left = 0;

    function automatic longint sat_range(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat32(longint x);
        return sat_range(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint sat48(longint x);
        return sat_range(x, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    endfunction

    // round(a*b / 2^sh) half away from zero, magnitude clamped at 2^62
    function automatic longint round_mul(longint a, longint b, int sh);
        logic [127:0] p;
        logic [63:0] x, y;
        longint r;
        bit neg;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        neg = (a < 0) != (b < 0);
        p = {64'd0, x} * {64'd0, y};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'(64'd1 << 62)) p = 128'(64'd1 << 62);
        r = longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    // trunc(num * 2^F / den), den > 0, saturated to 48 bits
    function automatic longint gain_div(longint num, longint den);
        logic [127:0] n, q;
        n = {64'd0, 64'(num < 0 ? -num : num)} << COV_FRAC_BITS;
        q = n / {64'd0, 64'(den)};
        if (q > 128'(COV_MAX)) return num < 0 ? -(64'sd1 <<< 47) : (64'sd1 <<< 47) - 1;
        return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_estimate filter_step(logic [31:0] am_raw, logic [31:0] rm_raw);
        longint am, rm, d0, e, err, k0, k1, t0, t1, rate;
        t_estimate res;
        am = longint'(signed'(am_raw));
        rm = longint'(signed'(rm_raw));
        k0 = 0;
        k1 = 0;
        est_angle = sat32(est_angle + round_mul(rm - est_bias, dt, 24));
        d0 = q_angle - p_ab - p_ba;
        p_aa = sat48(p_aa + round_mul(d0, dt, 24));
        p_ab = sat48(p_ab + round_mul(-p_bb, dt, 24));
        p_ba = sat48(p_ba + round_mul(-p_bb, dt, 24));
        p_bb = sat48(p_bb + round_mul(q_bias, dt, 24));
        err = am - est_angle;
        e = r_meas + p_aa;
        if (e > 0) begin
            k0 = gain_div(p_aa, e);
            k1 = gain_div(p_ba, e);
        end
        t0 = p_aa;
        t1 = p_ab;
        p_aa = sat48(p_aa - round_mul(k0, t0, COV_FRAC_BITS));
        p_ab = sat48(p_ab - round_mul(k0, t1, COV_FRAC_BITS));
        p_ba = sat48(p_ba - round_mul(k1, t0, COV_FRAC_BITS));
        p_bb = sat48(p_bb - round_mul(k1, t1, COV_FRAC_BITS));
        est_angle = sat32(est_angle + round_mul(k0, err, COV_FRAC_BITS));
        est_bias = sat32(est_bias + round_mul(k1, err, COV_FRAC_BITS));
        rate = sat32(rm - est_bias);
        res.angle = est_angle[31:0];
        res.rate = rate[31:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s at result %0d: got %h want %h", what, n_checked, got, want);
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic send_item(logic [31:0] am, logic [31:0] rm);
        int gap;
        gap = send_gaps ? rand_gap() : 0;
        // with no gap, valid stays high and the new item follows directly
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.f0 <= am;
        in_ch.f1 <= rm;
        do @(posedge i_clk); while (!in_ch.ready);
        estimates_due.push_back(filter_step(am, rm));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (estimates_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
        case (idx)
            REG_ANGLE_NOISE:   q_angle = longint'(val);
            REG_BIAS_NOISE:    q_bias = longint'(val);
            REG_MEASURE_NOISE: r_meas = longint'(val[23:0]) <<< (COV_FRAC_BITS - 16);
            REG_SAMPLE_PERIOD: dt = longint'(val[23:0]);
            default: ;
        endcase
    endtask

    task automatic set_all(logic [CFG_W-1:0] qa, logic [CFG_W-1:0] qg,
                           logic [CFG_W-1:0] rn, logic [CFG_W-1:0] per);
        wait_idle();
        cfg_write(REG_ANGLE_NOISE, qa);
        cfg_write(REG_BIAS_NOISE, qg);
        cfg_write(REG_MEASURE_NOISE, rn);
        cfg_write(REG_SAMPLE_PERIOD, per);
    endtask

    // plausible sensor stream: angle jittering about a fixed base, modest rate with offset
    task automatic send_motion(int count);
        int base, drift;
        base = $urandom_range(90 << 16) - (45 << 16);
        drift = $urandom_range(4 << 16) - (2 << 16);
        repeat (count) begin
            send_item(base + $urandom_range(1 << 16) - (1 << 15),
                      drift + $urandom_range(20 << 16) - (10 << 16));
        end
    endtask

    task automatic send_noise(int count);
        repeat (count) send_item($urandom, $urandom);
    endtask

    task automatic test_directed();
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h0000_0001);
        send_item(32'h0001_0000, 32'hFFFF_0000);
        // zero time step: prediction holds
        set_all(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'd1, 40'd0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h1234_5678);
        // largest step drives the cross terms strongly negative
        set_all(40'd0, 40'd0, 40'd1, 40'hFF_FFFF_FFFF);
        repeat (6) send_item(32'h8000_0000, 32'h7FFF_FFFF);
        set_all(40'hFF_FFFF_FFFF, 40'd0, 40'hFF_FFFF_FFFF, 40'd1);
        repeat (4) send_item(32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_settings_sweep();
        set_all(ANGLE_NOISE_RST, BIAS_NOISE_RST, 40'(MEASURE_NOISE_RST),
                40'(SAMPLE_PERIOD_RST));
        send_motion(40);
        set_all(40'd0, 40'hFF_FFFF_FFFF, 40'h00_00FF_FFFF, 40'h00_00FF_FFFF);
        send_motion(20);
        send_noise(10);
        set_all(40'd1, 40'd1, 40'd1, 40'd1);
        send_motion(20);
        set_all(40'($urandom_range(1 << 20)), 40'($urandom_range(1 << 16)),
                40'd65536, 40'd83886);
        send_motion(40);
    endtask

    task automatic test_random();
        int phase;
        for (phase = 0; phase < 24; phase++) begin
            set_all(40'({$urandom, $urandom}),
                    ($urandom_range(3) == 0) ? 40'({$urandom, $urandom})
                                             : 40'($urandom_range(1 << 24)),
                    40'({$urandom, $urandom}),
                    ($urandom_range(4) == 0) ? 40'({$urandom, $urandom})
                                             : 40'($urandom_range(1 << 18)));
            send_gaps = phase % 5 != 2;
            sink_stalls = phase % 7 != 3;
            send_motion(42);
            send_noise(8);
        end
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // result sink with random back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (sink_stalls && $urandom_range(9) == 0) stall_left <= rand_gap();
        end
    end

    always @(posedge i_clk) begin
        t_estimate want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (estimates_due.size() == 0) begin
                report("unexpected result", out_ch.f0, 32'h0);
            end else begin
                want = estimates_due.pop_front();
                if (out_ch.f0 !== want.angle) report("angle_est", out_ch.f0, want.angle);
                if (out_ch.f1 !== want.rate) report("rate_est", out_ch.f1, want.rate);
            end
            n_checked++;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.f0 = '0;
        in_ch.f1 = '0;
        out_ch.ready = 1'b0;
        q_angle = longint'(ANGLE_NOISE_RST);
        q_bias = longint'(BIAS_NOISE_RST);
        r_meas = longint'(MEASURE_NOISE_RST) <<< (COV_FRAC_BITS - 16);
        dt = longint'(SAMPLE_PERIOD_RST);
        est_angle = 0;
        est_bias = 0;
        p_aa = longint'(COV_ONE);
        p_ab = 0;
        p_ba = 0;
        p_bb = longint'(COV_ONE);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_settings_sweep();
        test_random();

        wait_idle();
        $display("sent %0d items, checked %0d results, %0d register writes",
                 n_sent, n_checked, n_cfg);
        $display("covered field extremes, zero and maximum time step, noise extremes");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
